FILE: rtl/core/prq_pkg.sv
// ============================================================================
// prq_pkg
// Shared types and constants for the priority ready queue.
// ============================================================================
package prq_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;

    localparam int unsigned TAG_W   = 8;
    localparam int unsigned PRIO_W  = 32;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ENTRY_W = TAG_W + PRIO_W;
    localparam int unsigned IN_W    = 40;
    localparam int unsigned OUT_W   = 48;

    typedef enum logic {
        REQ_ENQUEUE = 1'b0,
        REQ_DEQUEUE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/core/priority_ready_queue.sv
// ============================================================================
// priority_ready_queue
// Bounded ready queue with linear-scan highest-priority dequeue.
//
// Usage:
//   Input stream (s_*): one transfer per request. s_tuser selects enqueue (0)
//   or dequeue (1); s_tdata carries the tag and priority for an enqueue.
//   Output stream (m_*): exactly one transfer per request, in request order.
//   Entries live in a single-port-read, single-port-write synchronous RAM.
//   An enqueue writes the tail and then reports from the final state. A
//   dequeue reads every held entry to find the maximum, then moves the
//   entries after the winner down one place (one RAM read and one RAM
//   write per cycle), then reports. One request is in service at a time.
//   A finished result sits in the output register; the next request is
//   taken while it waits. If the receiver stalls, the following result holds
//   in the final state until the register frees, and s_tready stays low.
//   Reset empties the queue (count to zero); RAM contents are not cleared.
// ============================================================================
module priority_ready_queue #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [7:0] proc_tag, [39:8] proc_priority
    input  logic [prq_pkg::IN_W-1:0]  s_tdata,
    // [0] req_type
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [0] found, [8:1] out_tag, [40:9] out_priority, [41] accepted,
    // [46:42] count_after, [47] is_empty
    output logic [prq_pkg::OUT_W-1:0] m_tdata
);
    import prq_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] mem_rd_data;
    logic               mem_rd_en;
    logic [AW-1:0]      mem_rd_addr;
    logic               mem_wr_en;
    logic [AW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      iss_idx_reg, iss_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [TAG_W-1:0]   best_tag_reg, best_tag_next;
    logic [PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic               found_reg, found_next;
    logic               acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]   m_data_reg, m_data_next;

    logic               s_xfer;
    logic               out_free;
    logic               iss_more;
    logic [TAG_W-1:0]   rd_tag;
    logic [PRIO_W-1:0]  rd_prio;
    logic [CW+4:0]      cnt_ext;
    logic [COUNT_W-1:0] cnt_out;
    logic               take_best;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign iss_more = iss_idx_reg < count_reg;
    assign rd_tag   = mem_rd_data[TAG_W-1:0];
    assign rd_prio  = mem_rd_data[ENTRY_W-1:TAG_W];
    assign cnt_ext  = {5'b0, count_reg};
    assign cnt_out  = cnt_ext[COUNT_W-1:0];
    assign take_best = (rd_idx_reg == '0) || (rd_prio > best_prio_reg);

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
        begin
            mem_rd_data <= mem[mem_rd_addr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (s_tuser == REQ_DEQUEUE && count_reg != '0)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_SCAN:
            begin
                if (!iss_more && !rd_pend_reg)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!iss_more && !rd_pend_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        count_next     = count_reg;
        iss_idx_next   = iss_idx_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        best_idx_next  = best_idx_reg;
        best_tag_next  = best_tag_reg;
        best_prio_next = best_prio_reg;
        found_next     = found_reg;
        acc_next       = acc_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = iss_idx_reg[AW-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = count_reg[AW-1:0];
        mem_wr_data    = s_tdata[ENTRY_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    found_next     = 1'b0;
                    acc_next       = 1'b0;
                    best_tag_next  = '0;
                    best_prio_next = '0;
                    iss_idx_next   = '0;
                    if (s_tuser == REQ_ENQUEUE)
                    begin
                        if (count_reg < CW'(QUEUE_DEPTH))
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                            acc_next   = 1'b1;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        found_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (iss_more)
                begin
                    mem_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = iss_idx_reg[AW-1:0];
                    iss_idx_next = iss_idx_reg + CW'(1);
                end
                if (rd_pend_reg && take_best)
                begin
                    best_idx_next  = rd_idx_reg;
                    best_tag_next  = rd_tag;
                    best_prio_next = rd_prio;
                end
                if (!iss_more && !rd_pend_reg)
                    iss_idx_next = CW'(best_idx_reg) + CW'(1);
            end
            ST_SHIFT:
            begin
                if (iss_more)
                begin
                    mem_rd_en    = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next  = iss_idx_reg[AW-1:0];
                    iss_idx_next = iss_idx_reg + CW'(1);
                end
                if (rd_pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = rd_idx_reg - AW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (!iss_more && !rd_pend_reg)
                    count_next = count_reg - CW'(1);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(count_reg == '0), cnt_out, acc_reg,
                                    best_prio_reg, best_tag_reg, found_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_idx_reg   <= iss_idx_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_tag_reg  <= best_tag_next;
        best_prio_reg <= best_prio_next;
        found_reg     <= found_next;
        acc_reg       <= acc_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_one_in_service: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> !s_tready)
        else $error("second request taken while one is in service");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_rd_en |-> (iss_idx_reg < count_reg))
        else $error("RAM read beyond held entries");

    a_shift_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && mem_wr_en) |->
            (CW'(mem_wr_addr) >= CW'(best_idx_reg) && rd_idx_reg != '0))
        else $error("shift write below the removed entry");

    a_fin_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> m_valid_reg)
        else $error("finished result not presented");
endmodule
